>>> hw/rtl/scos_pkg.sv
// shared types and codes for the sparse column overlay store
package scos_pkg;

  localparam int PIX_W = 8;

  // operation codes carried in the func field
  localparam logic [1:0] FN_MODIFY     = 2'd0;
  localparam logic [1:0] FN_QUERY_XOR  = 2'd1;
  localparam logic [1:0] FN_QUERY_ANDN = 2'd2;

  // result status codes
  localparam logic [2:0] ST_MERGED   = 3'd0;
  localparam logic [2:0] ST_REMOVED  = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_DROPPED  = 3'd3;
  localparam logic [2:0] ST_QUERY    = 3'd4;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       x;
    logic [2:0]       line;
    logic [PIX_W-1:0] pixels;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] result_pixels;
    logic [2:0]       status;
    logic             had_patch;
    logic [7:0]       entry_count;
  } out_item_t;

endpackage

>>> hw/rtl/scos_chan_if.sv
// valid/ready channel carrying one payload struct
interface scos_chan_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/scos_word_cell.sv
// one occupancy bitmap word in the rotating bitmap ring
module scos_word_cell #(
  parameter int WORD_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift_en,
  input  logic [WORD_BITS-1:0] d_in,
  input  logic                 load_en,
  input  logic [WORD_BITS-1:0] load_d,
  output logic [WORD_BITS-1:0] q
);
  logic [WORD_BITS-1:0] word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else if (load_en) begin
      word_r <= load_d;
    end else if (shift_en) begin
      word_r <= d_in;
    end
  end

  assign q = word_r;
endmodule

>>> hw/rtl/scos_patch_cell.sv
// one patch entry in the rotating patch list ring
module scos_patch_cell (
  input  logic                       clk,
  input  logic                       shift_en,
  input  logic [scos_pkg::PIX_W-1:0] d_in,
  output logic [scos_pkg::PIX_W-1:0] q
);
  logic [scos_pkg::PIX_W-1:0] patch_r;

  // contents undefined until written, only entries below the count are used
  always_ff @(posedge clk) begin
    if (shift_en) begin
      patch_r <= d_in;
    end
  end

  assign q = patch_r;
endmodule

>>> hw/rtl/sparse_column_overlay_store_unit.sv
// top level: bitmap-indexed sparse store of column patches built from two cell rings
//
//  channel | direction | payload                                    | handshake
//  in_chan | sink      | func, x, line, pixels                      | valid/ready
//  out_chan| source    | result_pixels, status, had_patch, entry_cnt| valid/ready
//
// one transaction at a time; an accepted transaction passes through S_PREP, which
// reduces x and line into the grid by repeated subtraction, then S_WALK, S_LIST and
// S_DONE; the result is presented and the next transaction can be taken in the same cycle
// the bitmap ring is walked once, a word a cycle, to find the rank of the position
// the patch ring then turns once (LIST_DEPTH + 1 steps) and is rewritten in flight,
// closing up or opening a gap at the rank, so no random access into the list is needed
// synchronous reset clears the bitmap words and the count at once; list contents
// stay undefined; a full output register holds the block in its last step
module sparse_column_overlay_store_unit #(
  parameter int LIST_DEPTH = 128,
  parameter int WORD_BITS  = 16,
  parameter int ROW_COUNT  = 8,
  parameter int GRID_WIDTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  scos_chan_if.sink   in_chan,
  scos_chan_if.source out_chan
);

  localparam int WORDS_PER_ROW = (GRID_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_TOTAL    = ROW_COUNT * WORDS_PER_ROW;
  localparam int WIW  = (WORD_TOTAL > 1) ? $clog2(WORD_TOTAL) : 1;
  localparam int WRW  = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
  localparam int ROWW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int CW   = $clog2(WORDS_PER_ROW * WORD_BITS + WORD_BITS + 1);
  localparam int BW   = $clog2(WORD_BITS);
  localparam int PCW  = $clog2(WORD_BITS + 1);
  localparam int CNTW = $clog2(LIST_DEPTH + 1);
  localparam int KW   = $clog2(LIST_DEPTH + 2);
  localparam int PIXW = scos_pkg::PIX_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_WALK = 5'b00100,
    S_LIST = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  // population count of one bitmap word
  function automatic logic [PCW-1:0] popcnt(input logic [WORD_BITS-1:0] v);
    logic [PCW-1:0] n;
    n = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      n = n + PCW'(v[b]);
    end
    return n;
  endfunction

  state_t state_r, state_nxt;

  // captured transaction
  logic [1:0]      func_r;
  logic [7:0]      x_r;
  logic [2:0]      line_r;
  logic [PIXW-1:0] pix_r;

  // bitmap walk
  logic [CW-1:0]        col_r;
  logic [WRW-1:0]       wir_r;
  logic [ROWW-1:0]      row_r;
  logic [WIW-1:0]       j_r;
  logic [CNTW-1:0]      rank_r;
  logic                 found_r;
  logic                 had_r;
  logic [BW-1:0]        off_r;
  logic [WORD_BITS-1:0] hword_r;
  logic [WIW-1:0]       hitcell_r;

  // list pass
  logic [KW-1:0]   k_r;
  logic [PIXW-1:0] b1_r, b2_r, ev_r;
  logic            del_r;

  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             out_valid_r;
  scos_pkg::out_item_t out_data_r, out_nxt;

  // ring wiring
  logic [WORD_BITS-1:0] wq [WORD_TOTAL];
  logic [PIXW-1:0]      pq [LIST_DEPTH];
  logic [WORD_BITS-1:0] tail_w, take_w, bm_new;
  logic [PIXW-1:0]      tail_p, wdata, merged;
  logic                 walk_en, list_en, bm_load, commit, in_acc;

  // walk decode
  logic [CW-1:0]   x_c;
  logic [BW-1:0]   off_w;
  logic            row_hit, hit;
  logic [PCW-1:0]  pc;

  // list decode
  logic is_mod, ins_m, mod_m, p_lt, p_eq;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  assign walk_en = (state_r == S_WALK);
  assign list_en = (state_r == S_LIST);
  assign commit  = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  assign tail_w = wq[WORD_TOTAL-1];
  assign tail_p = pq[LIST_DEPTH-1];

  // bitmap ring: word j sits in cell WORD_TOTAL-1-j, one full turn per walk
  for (genvar g = 0; g < WORD_TOTAL; g++) begin : g_word
    logic [WORD_BITS-1:0] d_in;
    if (g == 0) begin : g_head
      assign d_in = wq[WORD_TOTAL-1];
    end else begin : g_body
      assign d_in = wq[g-1];
    end
    scos_word_cell #(.WORD_BITS(WORD_BITS)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (walk_en),
      .d_in     (d_in),
      .load_en  (bm_load && (hitcell_r == WIW'(g))),
      .load_d   (bm_new),
      .q        (wq[g])
    );
  end

  // patch ring: entry i sits in cell LIST_DEPTH-1-i, the head cell takes the rewrite
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_patch
    logic [PIXW-1:0] d_in;
    if (g == 0) begin : g_head
      assign d_in = wdata;
    end else begin : g_body
      assign d_in = pq[g-1];
    end
    scos_patch_cell u_cell (
      .clk      (clk),
      .shift_en (list_en),
      .d_in     (d_in),
      .q        (pq[g])
    );
  end

  // walk: count set bits in every word before the position, and below it in its own word
  always_comb begin
    x_c     = CW'(x_r);
    row_hit = (32'(row_r) == 32'(line_r));
    hit     = !found_r && row_hit && (x_c >= col_r) && (x_c < col_r + CW'(WORD_BITS));
    off_w   = BW'(x_c - col_r);
    for (int b = 0; b < WORD_BITS; b++) begin
      take_w[b] = !found_r && (!hit || (BW'(b) < off_w));
    end
    pc = popcnt(tail_w & take_w);
  end

  // list pass modes
  assign is_mod = (func_r == scos_pkg::FN_MODIFY);
  assign ins_m  = is_mod && !had_r && (cnt_r < CNTW'(LIST_DEPTH));
  assign mod_m  = is_mod && had_r;
  // step k writes list position k-1
  assign p_lt   = (k_r <= KW'(rank_r));
  assign p_eq   = (k_r == KW'(rank_r) + KW'(1));
  assign merged = b1_r ^ pix_r;

  always_comb begin
    if (p_lt) begin
      wdata = b1_r;
    end else if (p_eq) begin
      if (ins_m) begin
        wdata = pix_r;
      end else if (mod_m) begin
        wdata = (merged == '0) ? tail_p : merged;
      end else begin
        wdata = b1_r;
      end
    end else if (ins_m) begin
      wdata = b2_r;
    end else if (mod_m && del_r) begin
      wdata = tail_p;
    end else begin
      wdata = b1_r;
    end
  end

  // final bitmap word and result
  always_comb begin
    bm_new        = hword_r;
    bm_new[off_r] = ins_m;
    bm_load       = commit && (ins_m || del_r);
    cnt_nxt       = cnt_r;
    out_nxt.had_patch     = had_r;
    out_nxt.result_pixels = '0;
    out_nxt.status        = scos_pkg::ST_QUERY;
    if (is_mod) begin
      if (del_r) begin
        cnt_nxt        = cnt_r - CNTW'(1);
        out_nxt.status = scos_pkg::ST_REMOVED;
      end else if (mod_m) begin
        out_nxt.result_pixels = ev_r ^ pix_r;
        out_nxt.status        = scos_pkg::ST_MERGED;
      end else if (ins_m) begin
        cnt_nxt               = cnt_r + CNTW'(1);
        out_nxt.result_pixels = pix_r;
        out_nxt.status        = scos_pkg::ST_INSERTED;
      end else begin
        out_nxt.status = scos_pkg::ST_DROPPED;
      end
    end else begin
      out_nxt.result_pixels = pix_r;
      if (had_r) begin
        case (func_r)
          scos_pkg::FN_QUERY_XOR:  out_nxt.result_pixels = pix_r ^ ev_r;
          scos_pkg::FN_QUERY_ANDN: out_nxt.result_pixels = pix_r & ~ev_r;
          default:                 out_nxt.result_pixels = pix_r;
        endcase
      end
    end
    out_nxt.entry_count = 8'(cnt_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_PREP;
      S_PREP: begin
        if (32'(x_r) < GRID_WIDTH && 32'(line_r) < ROW_COUNT) state_nxt = S_WALK;
      end
      S_WALK: if (j_r == WIW'(WORD_TOTAL - 1)) state_nxt = S_LIST;
      S_LIST: if (k_r == KW'(LIST_DEPTH)) state_nxt = S_DONE;
      S_DONE: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= out_nxt;
    end
    case (state_r)
      S_IDLE: begin
        func_r  <= in_chan.data.func;
        x_r     <= in_chan.data.x;
        line_r  <= in_chan.data.line;
        pix_r   <= in_chan.data.pixels;
        col_r   <= '0;
        wir_r   <= '0;
        row_r   <= '0;
        j_r     <= '0;
        rank_r  <= '0;
        found_r <= 1'b0;
        had_r   <= 1'b0;
        del_r   <= 1'b0;
        k_r     <= '0;
      end
      S_PREP: begin
        // bring x and line into the grid by repeated subtraction
        if (32'(x_r) >= GRID_WIDTH) begin
          x_r <= x_r - 8'(GRID_WIDTH);
        end else if (32'(line_r) >= ROW_COUNT) begin
          line_r <= line_r - 3'(ROW_COUNT);
        end
      end
      S_WALK: begin
        rank_r <= rank_r + CNTW'(pc);
        j_r    <= j_r + WIW'(1);
        if (hit) begin
          found_r   <= 1'b1;
          had_r     <= tail_w[off_w];
          off_r     <= off_w;
          hword_r   <= tail_w;
          hitcell_r <= WIW'(WORD_TOTAL - 1) - j_r;
        end
        if (wir_r == WRW'(WORDS_PER_ROW - 1)) begin
          wir_r <= '0;
          col_r <= '0;
          row_r <= row_r + ROWW'(1);
        end else begin
          wir_r <= wir_r + WRW'(1);
          col_r <= col_r + CW'(WORD_BITS);
        end
      end
      S_LIST: begin
        k_r  <= k_r + KW'(1);
        b1_r <= tail_p;
        b2_r <= b1_r;
        if (p_eq) begin
          ev_r  <= b1_r;
          del_r <= mod_m && (merged == '0);
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(LIST_DEPTH))
    else $error("patch count above list depth");

  a_acc_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_PREP)
    else $error("accepted transaction did not start");

  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LIST |-> found_r)
    else $error("bitmap walk missed the position");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("finished transaction not presented");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    commit && is_mod && ins_m |=> cnt_r == $past(cnt_r) + CNTW'(1))
    else $error("insert did not grow the count");
`endif

endmodule
